FILE: hdl/tun_pkg.sv
// tun_pkg: widths and stage payload types for the triangle unit normal pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tun_pkg;

  localparam int CW = 16;   // corner coordinate, Q8.8
  localparam int EW = 17;   // edge component
  localparam int PW = 34;   // edge product
  localparam int NW = 35;   // cross product component
  localparam int MW = 34;   // cross product magnitude
  localparam int QW = 68;   // squared magnitude
  localparam int SW = 70;   // squared length
  localparam int DW = 102;  // root search accumulators
  localparam int RW = 15;   // quotient bits, 0..16384
  localparam int OW = 16;   // output component, Q1.14
  localparam int SHIFT_T = 30;

  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
  } tun_cross_t;

  typedef struct packed {
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] p;
    logic signed [DW-1:0] t;
    logic [RW-1:0]        q;
    logic                 neg;
  } tun_comp_t;

  typedef struct packed {
    tun_comp_t [2:0]  c;
    logic [SW-1:0]    s;
    logic             degen;
  } tun_iter_t;

endpackage

FILE: hdl/triangle_unit_normal.sv
// triangle_unit_normal: unit face normal of a triangle, Q8.8 corners in, Q1.14 normal out
//
// Usage:
//   input channel: in_valid / in_stall with the nine corner coordinates a_*, b_*, c_*
//   output channel: out_valid / out_stall with unit_x, unit_y, unit_z and degenerate
//   a transaction moves at a rising edge with valid high and stall low
// Throughput: one triangle per cycle, with no gaps, while the output is not stalled.
// Pipeline: edge, edge product and cross product registers, then the squared length
//   and seed registers, the bit-per-stage normalization search (one quotient bit per
//   stage) and one output register.
// Stall: when the output register holds an untaken result and out_stall is high,
//   the whole pipeline freezes and in_stall is raised; nothing is lost or repeated.
// Reset: synchronous, clears every valid bit; the pipeline restarts empty.
// Zero-length cross product gives the zero vector with degenerate set.
// depends on tun_pkg, tun_cross, tun_len, tun_root
`timescale 1ns / 1ps

module triangle_unit_normal (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [tun_pkg::CW-1:0] a_x,
  input  logic signed [tun_pkg::CW-1:0] a_y,
  input  logic signed [tun_pkg::CW-1:0] a_z,
  input  logic signed [tun_pkg::CW-1:0] b_x,
  input  logic signed [tun_pkg::CW-1:0] b_y,
  input  logic signed [tun_pkg::CW-1:0] b_z,
  input  logic signed [tun_pkg::CW-1:0] c_x,
  input  logic signed [tun_pkg::CW-1:0] c_y,
  input  logic signed [tun_pkg::CW-1:0] c_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [tun_pkg::OW-1:0] unit_x,
  output logic signed [tun_pkg::OW-1:0] unit_y,
  output logic signed [tun_pkg::OW-1:0] unit_z,
  output logic                          degenerate
);
  import tun_pkg::*;

  logic       en;
  logic       cross_valid, iter_valid, root_valid;
  tun_cross_t xprod;
  tun_iter_t  iter, root;
  logic signed [OW-1:0] unit_next [3];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  tun_cross u_cross (
    .clk, .rst, .en, .in_valid,
    .a_x, .a_y, .a_z, .b_x, .b_y, .b_z, .c_x, .c_y, .c_z,
    .cross_valid, .xprod
  );

  tun_len u_len (
    .clk, .rst, .en, .cross_valid, .xprod, .iter_valid, .iter
  );

  tun_root u_root (
    .clk, .rst, .en, .iter_valid, .iter, .root_valid, .root
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (root.degen) begin
        unit_next[j] = '0;
      end else if (root.c[j].neg) begin
        unit_next[j] = -$signed(OW'(root.c[j].q));
      end else begin
        unit_next[j] = $signed(OW'(root.c[j].q));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_x     <= unit_next[0];
      unit_y     <= unit_next[1];
      unit_z     <= unit_next[2];
      degenerate <= root.degen;
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> unit_x == 0 && unit_y == 0 && unit_z == 0)
    else $error("degenerate result with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unit_x >= -16384 && unit_x <= 16384 && unit_y >= -16384 &&
                  unit_y <= 16384 && unit_z >= -16384 && unit_z <= 16384)
    else $error("normal component out of range");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(unit_x) && $stable(degenerate))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

FILE: hdl/tun_cross.sv
// tun_cross: edge vectors, edge products and cross product in three stages
// depends on tun_pkg
`timescale 1ns / 1ps

module tun_cross (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [tun_pkg::CW-1:0] a_x,
  input  logic signed [tun_pkg::CW-1:0] a_y,
  input  logic signed [tun_pkg::CW-1:0] a_z,
  input  logic signed [tun_pkg::CW-1:0] b_x,
  input  logic signed [tun_pkg::CW-1:0] b_y,
  input  logic signed [tun_pkg::CW-1:0] b_z,
  input  logic signed [tun_pkg::CW-1:0] c_x,
  input  logic signed [tun_pkg::CW-1:0] c_y,
  input  logic signed [tun_pkg::CW-1:0] c_z,
  output logic                      cross_valid,
  output tun_pkg::tun_cross_t       xprod
);
  import tun_pkg::*;

  logic                 v1, v2;
  logic signed [EW-1:0] vx, vy, vz, wx, wy, wz;
  logic signed [PW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      cross_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      cross_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx <= EW'(b_x) - EW'(a_x);
      vy <= EW'(b_y) - EW'(a_y);
      vz <= EW'(b_z) - EW'(a_z);
      wx <= EW'(c_x) - EW'(a_x);
      wy <= EW'(c_y) - EW'(a_y);
      wz <= EW'(c_z) - EW'(a_z);
      p_yz <= vy * wz;
      p_zy <= vz * wy;
      p_zx <= vz * wx;
      p_xz <= vx * wz;
      p_xy <= vx * wy;
      p_yx <= vy * wx;
      xprod.nx <= NW'(p_yz) - NW'(p_zy);
      xprod.ny <= NW'(p_zx) - NW'(p_xz);
      xprod.nz <= NW'(p_xy) - NW'(p_yx);
    end
  end

endmodule

FILE: hdl/tun_len.sv
// tun_len: squared length of the cross product and the root search seeds
// depends on tun_pkg
`timescale 1ns / 1ps

module tun_len (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                cross_valid,
  input  tun_pkg::tun_cross_t xprod,
  output logic                iter_valid,
  output tun_pkg::tun_iter_t  iter
);
  import tun_pkg::*;

  logic                 v4;
  logic [QW-1:0]        sq [3];
  logic [2:0]           neg;
  logic signed [NW-1:0] n [3];
  logic [NW-1:0]        mag [3];
  logic [SW-1:0]        s;

  assign n[0] = xprod.nx;
  assign n[1] = xprod.ny;
  assign n[2] = xprod.nz;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = n[j][NW-1] ? NW'(-n[j]) : NW'(n[j]);
    end
    s = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      iter_valid <= 1'b0;
    end else if (en) begin
      v4 <= cross_valid;
      iter_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq[j]  <= mag[j][MW-1:0] * mag[j][MW-1:0];
        neg[j] <= n[j][NW-1];
      end
      iter.s     <= s;
      iter.degen <= (s == '0);
      for (int j = 0; j < 3; j++) begin
        iter.c[j].d   <= $signed(DW'(s));
        iter.c[j].p   <= -$signed(DW'(s));
        iter.c[j].t   <= $signed(DW'({sq[j], {SHIFT_T{1'b0}}}));
        iter.c[j].q   <= '0;
        iter.c[j].neg <= neg[j];
      end
    end
  end

endmodule

FILE: hdl/tun_root.sv
// tun_root: bit-per-stage search for round(|n| * 2^14 / sqrt(S)) on three components
// keeps d = (2q-1)^2 * S and p = (2q-1) * S so each stage only adds and compares
// depends on tun_pkg
`timescale 1ns / 1ps

module tun_root (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               iter_valid,
  input  tun_pkg::tun_iter_t iter,
  output logic               root_valid,
  output tun_pkg::tun_iter_t root
);
  import tun_pkg::*;

  tun_iter_t  st  [RW+1];
  logic       vld [RW+1];

  assign st[0]  = iter;
  assign vld[0] = iter_valid;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int K = RW - 1 - i;
    tun_iter_t            nxt;
    logic signed [DW-1:0] sx;
    logic signed [DW-1:0] trial [3];

    assign sx = $signed(DW'(st[i].s));

    always_comb begin
      nxt = st[i];
      for (int j = 0; j < 3; j++) begin
        trial[j] = st[i].c[j].d + (st[i].c[j].p <<< (K + 2)) + (sx <<< (2 * K + 2));
        if (trial[j] <= st[i].c[j].t) begin
          nxt.c[j].d = trial[j];
          nxt.c[j].p = st[i].c[j].p + (sx <<< (K + 1));
          nxt.c[j].q = st[i].c[j].q | (RW'(1) << K);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign root_valid = vld[RW];
  assign root       = st[RW];

endmodule

FILE: bench/tb_triangle_unit_normal.sv
// tb_triangle_unit_normal: self-checking bench for the triangle unit normal pipeline
// drives corner triangles, predicts the Q1.14 normal and degenerate flag, checks every result
// depends on tun_pkg and triangle_unit_normal
`timescale 1ns / 1ps

module tb_triangle_unit_normal;
  import tun_pkg::*;

  localparam int N_RANDOM   = 1800;
  localparam int WATCHDOG   = 3000;
  localparam int HOLD_LEN   = 300;
  localparam int HOLD_AT    = 400;
  localparam int QUIET_LO   = 1000;
  localparam int QUIET_HI   = 1300;
  localparam int DRAIN_WAIT = 40;

  // nine coordinates, a_x at the bottom, c_z at the top
  typedef logic [9*CW-1:0] tri_t;

  typedef struct packed {
    logic signed [OW-1:0] ux;
    logic signed [OW-1:0] uy;
    logic signed [OW-1:0] uz;
    logic                 degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [CW-1:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [CW-1:0] c_x = '0, c_y = '0, c_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OW-1:0] unit_x, unit_y, unit_z;
  logic degenerate;

  tri_t    tri_pending[$];
  normal_t normal_expected[$];
  int      tri_total = 0;
  int      tri_sent = 0;
  int      normal_seen = 0;
  int      hold_left = 0;
  int      idle_cycles = 0;
  bit      failed = 1'b0;

  triangle_unit_normal dut (.*);

  always #10 clk = ~clk;

  // largest q with (2q-1)^2 * len2 <= n^2 * 2^30, rounding half away from zero
  function automatic logic [OW-1:0] unit_component(longint n, logic [127:0] len2);
    logic [127:0] mag, rhs, odd, lhs;
    int lo, hi, mid;
    mag = (n < 0) ? 128'(-n) : 128'(n);
    rhs = (mag * mag) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 128'(2 * mid - 1);
      lhs = len2 * odd * odd;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (n < 0) ? OW'(-lo) : OW'(lo);
  endfunction

  function automatic normal_t face_normal(tri_t t);
    longint p[9];
    longint vx, vy, vz, wx, wy, wz, nx, ny, nz;
    logic [127:0] len2, mx, my, mz;
    normal_t r;
    for (int i = 0; i < 9; i++) p[i] = longint'($signed(t[i*CW +: CW]));
    vx = p[3] - p[0]; vy = p[4] - p[1]; vz = p[5] - p[2];
    wx = p[6] - p[0]; wy = p[7] - p[1]; wz = p[8] - p[2];
    nx = vy * wz - vz * wy;
    ny = vz * wx - vx * wz;
    nz = vx * wy - vy * wx;
    mx = (nx < 0) ? 128'(-nx) : 128'(nx);
    my = (ny < 0) ? 128'(-ny) : 128'(ny);
    mz = (nz < 0) ? 128'(-nz) : 128'(nz);
    len2 = mx * mx + my * my + mz * mz;
    if (len2 == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, degen: 1'b1};
    end else begin
      r.ux = unit_component(nx, len2);
      r.uy = unit_component(ny, len2);
      r.uz = unit_component(nz, len2);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz);
    return {CW'(cz), CW'(cy), CW'(cx), CW'(bz), CW'(by), CW'(bx), CW'(az), CW'(ay), CW'(ax)};
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(512)) - 256;
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    int k;
    k = $urandom_range(9);
    t = (9*CW)'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (k < 3) begin
      t = make_tri(small_coord(), small_coord(), small_coord(), small_coord(), small_coord(),
                   small_coord(), small_coord(), small_coord(), small_coord());
    end else if (k == 3) begin
      // coincident corners or a corner repeated: zero length cross product
      case ($urandom_range(2))
        0: t[6*CW-1:3*CW] = t[3*CW-1:0];
        1: t[9*CW-1:6*CW] = t[6*CW-1:3*CW];
        default: t[9*CW-1:6*CW] = t[3*CW-1:0];
      endcase
    end
    return t;
  endfunction

  // sender: a transaction leaves when valid is high and stall is low
  always @(posedge clk) begin
    tri_t t;
    bit   quiet;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        normal_expected.push_back(
          face_normal(make_tri(a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z)));
        tri_sent++;
      end
      if (!in_valid || !in_stall) begin
        quiet = (tri_sent >= QUIET_LO && tri_sent < QUIET_HI);
        if (tri_pending.size() > 0 && (quiet || $urandom_range(99) >= 36)) begin
          t = tri_pending.pop_front();
          {c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x} <= t;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks against the oldest prediction, stalls at random and holds a long stall at HOLD_AT
  always @(posedge clk) begin
    normal_t e;
    bit quiet;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (normal_expected.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d degenerate=%0b",
                   $time, unit_x, unit_y, unit_z, degenerate);
          failed = 1'b1;
        end else begin
          e = normal_expected.pop_front();
          if (unit_x !== e.ux) begin
            $display("%0t: unit_x expected %0d actual %0d", $time, e.ux, unit_x);
            failed = 1'b1;
          end
          if (unit_y !== e.uy) begin
            $display("%0t: unit_y expected %0d actual %0d", $time, e.uy, unit_y);
            failed = 1'b1;
          end
          if (unit_z !== e.uz) begin
            $display("%0t: unit_z expected %0d actual %0d", $time, e.uz, unit_z);
            failed = 1'b1;
          end
          if (degenerate !== e.degen) begin
            $display("%0t: degenerate expected %0b actual %0b", $time, e.degen, degenerate);
            failed = 1'b1;
          end
        end
        normal_seen++;
        if (normal_seen == HOLD_AT) hold_left = HOLD_LEN;
      end
      quiet = (normal_seen >= QUIET_LO && normal_seen < QUIET_HI);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 36);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    tri_t directed[$];
    directed.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
    directed.push_back(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256));
    directed.push_back(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0));
    directed.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));
    directed.push_back(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768));
    directed.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767));
    directed.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                -32768, 32767, -32768));
    directed.push_back(make_tri(32767, 32767, 32767, -32768, 32767, -32768,
                                32767, -32768, -32768));
    directed.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                -32768, -32768, 32767));
    directed.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    directed.push_back(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
    directed.push_back(make_tri(-32768, 0, 32767, 0, 0, 0, 32767, 0, -32768));
    directed.push_back(make_tri(0, 0, 0, 1, 2, 0, 2, 1, 1));
    directed.push_back(make_tri(100, -200, 300, 100, -200, 300, 5, 6, 7));
    directed.push_back(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0));
    directed.push_back(make_tri(0, 0, 0, 256, 256, 0, -256, 256, 0));
    directed.push_back(make_tri(1, 1, 1, -1, 1, 1, 1, -1, -1));
    directed.push_back(make_tri(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
    directed.push_back(make_tri(-1, -1, -1, -32768, -1, -1, -1, -1, -32768));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) tri_pending.push_back(directed[i]);
    tri_total = directed.size();
    // sender pauses until every directed result is back
    wait (tri_sent == tri_total && normal_expected.size() == 0);
    @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) tri_pending.push_back(random_tri());
    tri_total += N_RANDOM;

    wait (tri_sent == tri_total && normal_expected.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed && normal_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
